/* design/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error("%m failed");

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("%m failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr)

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/tbld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tbld_pkg;

  localparam int RAW_W           = 22;
  localparam int LVL_W           = 8;
  localparam int CNT_W           = 5;
  localparam int CAL_SAMPLES_DEF = 16;

  localparam logic [RAW_W-1:0] STEP_RESET = RAW_W'(10000);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_POST
  } state_t;

  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] dividend;
    logic [RAW_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LVL_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

/* design/tbld_div.sv */
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, quotient saturated to LVL_W bits.
module tbld_div (
  input  logic               clk,
  input  logic               rst,
  input  tbld_pkg::div_req_t req,
  output tbld_pkg::div_rsp_t rsp
);

  localparam int W   = tbld_pkg::RAW_W;
  localparam int L   = tbld_pkg::LVL_W;
  localparam int CW  = $clog2(W);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dsr;
  logic [W-1:0]  rem;
  logic [L-1:0]  q;
  logic          ovf;

  logic [W:0]    trial;
  logic [W:0]    diff;
  logic          fit;

  always_comb begin
    trial = {rem, dvd[W-1]};
    fit   = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      cnt <= '0;
    end else if (busy) begin
      rem <= fit ? diff[W-1:0] : trial[W-1:0];
      dvd <= {dvd[W-2:0], 1'b0};
      q   <= {q[L-2:0], fit};
      ovf <= ovf | q[L-1];
      cnt <= cnt + CW'(1);
    end
  end

  assign rsp.done = done;
  assign rsp.quot = ovf ? {L{1'b1}} : q;

endmodule

`default_nettype wire

/* design/touch_baseline_level_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Two-channel touch qualifier with per-channel noise floor.
// Input stream: s_tdata carries the raw reading, s_tuser the channel and the
// recalibrate flag. One result transfer on the m_ side for every input transfer.
// Config: cfg_valid/cfg_ready/cfg_data write the detection step; write only
// while no item is in flight. cfg_ready is always high.
// Timing: an item is registered, evaluated in the next cycle, then runs the
// bit-serial divider, which forms the quotient bit by bit, when a level must be
// computed; calibrating and below-threshold items, and any item while the step is
// zero, skip it. One item at a time: a new item is taken only once the previous
// result has been loaded into the output register.
// s_tready is high whenever no item is being processed, so a new item is taken
// while the previous result still waits in the output register.
// If the receiver stalls, the result holds in the output register and the
// next finished item waits until it is taken.
// Reset: floors and calibration counts clear, step returns to 10000, the
// output register empties.
module touch_baseline_level_detector #(
  parameter int CAL_SAMPLES = tbld_pkg::CAL_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [21:0] raw_reading, [23:22] zero
  input  logic [1:0]  s_tuser,   // [0] channel, [1] recalibrate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [0] touched, [8:1] level, [30:9] noise_floor_out, [31] zero
  output logic [1:0]  m_tuser,   // [0] out_channel, [1] calibrating
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [21:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int W  = tbld_pkg::RAW_W;
  localparam int L  = tbld_pkg::LVL_W;
  localparam int CW = tbld_pkg::CNT_W;

  tbld_pkg::state_t state, state_next;

  logic [W-1:0]  step;
  logic [W-1:0]  floor_r   [2];
  logic [CW-1:0] cnt       [2];
  logic [W-1:0]  floor_next[2];
  logic [CW-1:0] cnt_next  [2];

  logic          in_ch;
  logic [W-1:0]  in_raw;
  logic          in_recal;

  logic          res_touched;
  logic [L-1:0]  res_level;
  logic          res_cal;
  logic [W-1:0]  res_floor;

  logic          m_touched;
  logic [L-1:0]  m_level;
  logic          m_cal;
  logic [W-1:0]  m_floor;
  logic          m_ch;

  logic [CW-1:0] cnt_eff;
  logic [W-1:0]  floor_eff;
  logic [W-1:0]  floor_new;
  logic [W:0]    limit;
  logic          cal_now;
  logic          touch_now;
  logic          ge_now;
  logic          load_out;

  tbld_pkg::div_req_t dreq;
  tbld_pkg::div_rsp_t drsp;

  assign s_tready  = (state == tbld_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    cnt_eff   = in_recal ? '0 : cnt[in_ch];
    floor_eff = in_recal ? '0 : floor_r[in_ch];
    cal_now   = cnt_eff < CW'(CAL_SAMPLES);
    floor_new = (cal_now && in_raw > floor_eff) ? in_raw : floor_eff;
    limit     = {1'b0, floor_eff} + {1'b0, step};
    touch_now = !cal_now && ({1'b0, in_raw} > limit);
    ge_now    = !cal_now && ({1'b0, in_raw} >= limit);
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      floor_next[i] = in_recal ? '0 : floor_r[i];
      cnt_next[i]   = in_recal ? '0 : cnt[i];
    end
    floor_next[in_ch] = floor_new;
    cnt_next[in_ch]   = cal_now ? cnt_eff + CW'(1) : cnt_eff;
  end

  always_comb begin
    state_next    = state;
    dreq.start    = 1'b0;
    dreq.dividend = in_raw - floor_eff;
    dreq.divisor  = step;
    load_out      = 1'b0;
    unique case (state)
      tbld_pkg::S_IDLE: begin
        if (s_tvalid) state_next = tbld_pkg::S_EVAL;
      end
      tbld_pkg::S_EVAL: begin
        if (ge_now && step != '0) begin
          dreq.start = 1'b1;
          state_next = tbld_pkg::S_DIV;
        end else begin
          state_next = tbld_pkg::S_POST;
        end
      end
      tbld_pkg::S_DIV: begin
        if (drsp.done) state_next = tbld_pkg::S_POST;
      end
      tbld_pkg::S_POST: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = tbld_pkg::S_IDLE;
        end
      end
      default: state_next = tbld_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbld_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= tbld_pkg::STEP_RESET;
      for (int i = 0; i < 2; i++) begin
        floor_r[i] <= '0;
        cnt[i]     <= '0;
      end
    end else begin
      if (cfg_valid) step <= cfg_data;
      if (state == tbld_pkg::S_EVAL) begin
        for (int i = 0; i < 2; i++) begin
          floor_r[i] <= floor_next[i];
          cnt[i]     <= cnt_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch    <= s_tuser[0];
      in_recal <= s_tuser[1];
      in_raw   <= s_tdata[W-1:0];
    end
    if (state == tbld_pkg::S_EVAL) begin
      res_touched <= touch_now;
      res_cal     <= cal_now;
      res_floor   <= floor_new;
      res_level   <= ge_now ? {L{1'b1}} : '0;
    end else if (state == tbld_pkg::S_DIV && drsp.done) begin
      res_level <= drsp.quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_touched <= res_touched;
      m_level   <= res_level;
      m_cal     <= res_cal;
      m_floor   <= res_floor;
      m_ch      <= in_ch;
    end
  end

  assign m_tdata = {1'b0, m_floor, m_level, m_touched};
  assign m_tuser = {m_cal, m_ch};

  tbld_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  `ASSERT_ALWAYS(a_cnt0_bound, clk, rst, cnt[0] <= CW'(CAL_SAMPLES))
  `ASSERT_ALWAYS(a_cnt1_bound, clk, rst, cnt[1] <= CW'(CAL_SAMPLES))
  `ASSERT_IMPLY(a_cal_quiet, clk, rst, m_tvalid && m_cal, !m_touched && m_level == '0)
  `ASSERT_IMPLY(a_touch_level, clk, rst, m_tvalid && m_touched, m_level != '0)
  `ASSERT_IMPLY(a_div_done_state, clk, rst, drsp.done, state == tbld_pkg::S_DIV)

endmodule

`default_nettype wire

/* test/touch_baseline_level_detector_tb.sv */
`timescale 1ns / 1ps

module touch_baseline_level_detector_tb;

  localparam int RAW_W           = tbld_pkg::RAW_W;
  localparam int LVL_W           = tbld_pkg::LVL_W;
  localparam int CAL_SAMPLES_DEF = tbld_pkg::CAL_SAMPLES_DEF;
  localparam logic [RAW_W-1:0] STEP_RESET = tbld_pkg::STEP_RESET;

  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

  typedef struct packed {
    logic             channel;
    logic             touched;
    logic [LVL_W-1:0] level;
    logic             calibrating;
    logic [RAW_W-1:0] floor;
  } touch_result_t;

  class touch_level_predictor;
    logic [RAW_W-1:0] step;
    logic [RAW_W-1:0] floor_of[2];
    int               count_of[2];
    int               cal_samples;
    int               mismatches;
    touch_result_t    awaited[$];

    function new(int cal);
      cal_samples = cal;
      step        = STEP_RESET;
      floor_of[0] = '0;
      floor_of[1] = '0;
      count_of[0] = 0;
      count_of[1] = 0;
      mismatches  = 0;
    endfunction

    function void set_step(logic [RAW_W-1:0] v);
      step = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Input transfer: update floor/count and queue the expected result.
    function void note_reading(logic ch, logic [RAW_W-1:0] raw, logic recal);
      touch_result_t r;
      logic [RAW_W:0] limit;
      logic [RAW_W-1:0] q;
      r = '0;
      r.channel = ch;
      if (recal) begin
        floor_of[0] = '0;
        floor_of[1] = '0;
        count_of[0] = 0;
        count_of[1] = 0;
      end
      if (count_of[ch] < cal_samples) begin
        if (raw > floor_of[ch]) floor_of[ch] = raw;
        count_of[ch]++;
        r.calibrating = 1'b1;
      end else begin
        limit = {1'b0, floor_of[ch]} + {1'b0, step};
        r.touched = ({1'b0, raw} > limit);
        if ({1'b0, raw} < limit) begin
          r.level = '0;
        end else if (step == '0) begin
          r.level = '1;
        end else begin
          q = (raw - floor_of[ch]) / step;
          r.level = (q > 255) ? 8'd255 : q[LVL_W-1:0];
        end
      end
      r.floor = floor_of[ch];
      awaited.push_back(r);
    endfunction

    // Output transfer: compare with the oldest expectation.
    function void check_result(logic [31:0] tdata, logic [1:0] tuser);
      touch_result_t got, exp;
      got.channel     = tuser[0];
      got.calibrating = tuser[1];
      got.touched     = tdata[0];
      got.level       = tdata[8:1];
      got.floor       = tdata[30:9];
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: ch=%0d touched=%0d level=%0d cal=%0d floor=%0d",
                   got.channel, got.touched, got.level, got.calibrating, got.floor);
        return;
      end
      exp = awaited.pop_front();
      if (got.channel !== exp.channel || got.touched !== exp.touched ||
          got.level !== exp.level || got.calibrating !== exp.calibrating ||
          got.floor !== exp.floor) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp ch=%0d touched=%0d level=%0d cal=%0d floor=%0d",
                    " | got ch=%0d touched=%0d level=%0d cal=%0d floor=%0d"},
                   exp.channel, exp.touched, exp.level, exp.calibrating, exp.floor,
                   got.channel, got.touched, got.level, got.calibrating, got.floor);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [23:0]      s_tdata = '0;
  logic [1:0]       s_tuser = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [31:0]      m_tdata;
  logic [1:0]       m_tuser;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [RAW_W-1:0] cfg_data = '0;

  bit               quiet = 1'b0;
  logic [RAW_W-1:0] cal_top = '0;

  touch_level_predictor sb = new(CAL_SAMPLES_DEF);

  touch_baseline_level_detector dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_step(cfg_data);
      if (s_tvalid && s_tready) sb.note_reading(s_tuser[0], s_tdata[RAW_W-1:0], s_tuser[1]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Readings aimed at the current floor/step of the channel.
  function automatic logic [RAW_W-1:0] pick_reading(logic ch);
    longint fl, st, v;
    int k;
    fl = sb.floor_of[ch];
    st = sb.step;
    if (sb.count_of[ch] < sb.cal_samples) begin
      if ($urandom_range(0, 15) == 0) v = $urandom_range(0, RAW_MAX);
      else v = $urandom_range(0, cal_top);
    end else begin
      case ($urandom_range(0, 9))
        0:       v = 0;
        1:       v = RAW_MAX;
        2, 3, 4: v = fl + st + $urandom_range(0, 6) - 3;
        5, 6, 7: begin
          k = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 20);
          v = fl + st * k + $urandom_range(0, (st > 0) ? st - 1 : 0);
        end
        default: v = $urandom_range(0, RAW_MAX);
      endcase
    end
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  task automatic k_stall();
    int g;
    g = pick_gap();
    if (g > 0) begin
      m_tready <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      k_stall();
    end
  end

  task automatic send_reading(logic ch, logic [RAW_W-1:0] raw, logic recal);
    int g;
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, raw};
    s_tuser  <= {recal, ch};
    do @(posedge clk); while (!s_tready);
    g = pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_step(logic [RAW_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [RAW_W-1:0] step_v, int n, logic [RAW_W-1:0] top, bit q);
    logic ch;
    s_tvalid <= 1'b0;
    @(posedge clk);
    drain();
    write_step(step_v);
    cal_top = top;
    quiet   = q;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(0, 1);
      send_reading(ch, pick_reading(ch), (i == 0) || ($urandom_range(0, 249) == 0));
    end
    quiet = 1'b0;
  endtask

  initial begin
    logic [RAW_W-1:0] rd;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // calibration at reset step: ch0 floor 500, ch1 floor at full scale
    for (int i = 0; i < 16; i++) begin
      rd = (i == 7) ? 22'd500 : (i == 0) ? 22'd0 : 22'($urandom_range(0, 499));
      send_reading(1'b0, rd, i == 0);
      rd = (i == 3) ? RAW_MAX : 22'($urandom_range(0, RAW_MAX));
      send_reading(1'b1, rd, 1'b0);
    end
    send_reading(1'b0, 22'd10499, 1'b0);
    send_reading(1'b0, 22'd10500, 1'b0);
    send_reading(1'b0, 22'd10501, 1'b0);
    send_reading(1'b0, 22'd0, 1'b0);
    send_reading(1'b0, 22'd500, 1'b0);
    send_reading(1'b0, 22'd20500, 1'b0);
    send_reading(1'b0, 22'd2550500, 1'b0);
    send_reading(1'b0, 22'd2560499, 1'b0);
    send_reading(1'b0, RAW_MAX, 1'b0);
    send_reading(1'b1, RAW_MAX, 1'b0);
    send_reading(1'b1, 22'd0, 1'b0);
    send_reading(1'b1, 22'd123, 1'b1);

    run_phase(22'd1, 280, 22'd50, 1'b0);
    run_phase(RAW_MAX, 260, 22'd0, 1'b0);
    run_phase(22'd37, 280, 22'd3000, 1'b1);
    run_phase(STEP_RESET, 280, RAW_MAX, 1'b0);
    run_phase(22'($urandom_range(1, 2000)), 280, 22'd20000, 1'b0);
    run_phase(22'($urandom_range(1, RAW_MAX)), 280, 22'($urandom_range(0, RAW_MAX)), 1'b0);

    s_tvalid <= 1'b0;
    @(posedge clk);
    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
